>>> sv/cwrm_pkg.sv
// Package for the chopper wheel region map: sizes, codes and item layouts.
// No dependencies.
package cwrm_pkg;

    localparam int MaxEdges  = 64;
    localparam int AngleBits = 16;
    localparam int IdxBits   = 6;
    localparam int CntBits   = 7;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_FINALIZE = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_CAL   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic [1:0] RegSlot  = 2'd0;
    localparam logic [1:0] RegTooth = 2'd1;
    localparam logic [1:0] RegEdge  = 2'd2;

    // result item, packed into m_tdata with the last field (status) lowest
    typedef struct packed {
        logic [17:0] spacing_dev;
        logic [17:0] spacing_mean;
        logic [16:0] spacing_hi;
        logic [17:0] spacing_lo;
        logic [17:0] spacing;
        logic [15:0] midpoint;
        logic [5:0]  region_index;
        logic        kind;
        logic [1:0]  status;
    } result_t;

endpackage

>>> sv/cwrm_divider.sv
// Restoring divider, one quotient bit a cycle, for the ideal and mean spacings.
// Depends on cwrm_pkg.
module cwrm_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        negate,
    input  logic [23:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [23:0] quotient
);
    import cwrm_pkg::*;

    logic [23:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [7:0]  trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        trial = {r_reg, q_reg[23]};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 5'd0;
            busy_next = 1'b1;
            neg_next = negate;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = 7'(trial - {1'b0, divisor});
                q_next = {q_reg[22:0], 1'b1};
            end else begin
                r_next = trial[6:0];
                q_next = {q_reg[22:0], 1'b0};
            end
            cnt_next = 5'(cnt_reg + 5'd1);
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
    end

    assign done = !busy_reg && !start;
    assign quotient = neg_reg ? 24'(-q_reg) : q_reg;
endmodule

>>> sv/chopper_wheel_region_map.sv
// Chopper wheel region map top level: edge table, finalize walk, region search.
// Depends on cwrm_pkg and cwrm_divider.
//
// channel | dir | handshake            | payload
// s_      | in  | s_tvalid/s_tready    | tdata: command, edge_index, angle, edge_kind
// m_      | out | m_tvalid/m_tready    | tdata: result_t fields, tlast: last
// apb     | in  | psel/penable/pready  | slot_count, tooth_count, edge_count
//
// Load writes the table entry. Query reads, captures and compares one region at a time (one
// table read port, one compare unit), up to 3 + edge_count regions, between accept and emit.
// Finalize: a read and a kind check for each edge, the ideal-spacing divide,
// then a read, capture and calculate step per edge, then the mean divide.
// Results wait in the output register; the sequencer stalls before writing a new result while it is full and not taken.
// Reset clears the control state only; the edge table is not cleared.
module chopper_wheel_region_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[1:0] edge_index[7:2] angle[23:8] edge_kind[25:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata,  // status, kind, region_index, midpoint, spacing,
                                   // spacing_lo, spacing_hi, spacing_mean, spacing_dev
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cwrm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FCHK, S_FKRD, S_FKCHK, S_FDIV, S_FRDA, S_FRDB, S_FCALC, S_FMEAN,
        S_QRDA, S_QRDB, S_QCHK, S_QKIND, S_EMIT
    } state_t;

    logic [15:0] ang_mem [MaxEdges];
    logic [1:0]  kind_mem [MaxEdges];

    state_t      state_reg, state_next;
    logic [6:0]  slot_reg, tooth_reg, ecnt_reg;
    logic        cal_reg, cal_next;
    logic [5:0]  hint_reg, hint_next;
    logic        hv_reg, hv_next;
    logic [15:0] qang_reg, qang_next;
    logic [5:0]  i_reg, i_next;     // current edge / candidate
    logic [1:0]  ph_reg, ph_next;   // 0..2 hint candidates, 3 scan
    logic [15:0] a_reg, a_next;
    logic [1:0]  ka_reg, ka_next;
    logic [5:0]  rd_addr;
    logic [15:0] rd_ang;
    logic [1:0]  rd_kind;
    logic [23:0] ideal_reg, ideal_next;
    logic signed [23:0] sum_reg, sum_next;
    logic signed [17:0] smin_reg, smin_next;
    logic [16:0] smax_reg, smax_next;
    logic [17:0] serr_reg, serr_next;
    result_t     res_reg, res_next;
    logic        mv_reg, mv_next;
    logic        last_reg, last_next;
    logic        div_start, div_neg, div_done;
    logic [23:0] div_dvd, div_q;

    logic [1:0]  in_cmd;
    logic [5:0]  in_idx;
    logic [15:0] in_ang;
    logic [1:0]  in_kind;
    logic        s_acc, wr_cfg;
    logic [5:0]  nmax, nx;
    logic [16:0] b_ext;
    logic signed [17:0] sp;
    logic signed [18:0] err;
    logic [15:0] span, rel;

    assign in_cmd = s_tdata[1:0];
    assign in_idx = s_tdata[7:2];
    assign in_ang = s_tdata[23:8];
    assign in_kind = s_tdata[25:24];
    assign s_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign wr_cfg = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign nmax = 6'(ecnt_reg - 7'd1);
    assign nx = (i_reg == nmax) ? 6'd0 : 6'(i_reg + 6'd1);

    always_comb begin
        case (paddr[3:2])
            RegSlot:  prdata = {25'd0, slot_reg};
            RegTooth: prdata = {25'd0, tooth_reg};
            RegEdge:  prdata = {25'd0, ecnt_reg};
            default:  prdata = '0;
        endcase
    end

    cwrm_divider u_div (
        .aclk, .aresetn, .start(div_start), .negate(div_neg),
        .dividend(div_dvd), .divisor(ecnt_reg), .done(div_done), .quotient(div_q)
    );

    // table read address; the next edge stays on the port while a result waits
    always_comb begin
        case (state_reg)
            S_FRDB, S_FCALC, S_QRDB: rd_addr = nx;
            default:                 rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_cmd == CMD_LOAD) begin
            ang_mem[in_idx] <= in_ang;
            kind_mem[in_idx] <= in_kind;
        end
        rd_ang <= ang_mem[rd_addr];
        rd_kind <= kind_mem[rd_addr];
    end

    assign b_ext = (nx == 6'd0) ? {1'b1, rd_ang} : {1'b0, rd_ang};
    assign sp = 18'(signed'({1'b0, b_ext})) - 18'(signed'({2'b0, a_reg}));
    assign err = 19'(sp) - 19'(signed'({1'b0, ideal_reg[17:0]}));
    assign span = 16'(rd_ang - a_reg);
    assign rel = 16'(qang_reg - a_reg);

    always_comb begin
        state_next = state_reg;
        cal_next = cal_reg;
        hint_next = hint_reg;
        hv_next = hv_reg;
        qang_next = qang_reg;
        i_next = i_reg;
        ph_next = ph_reg;
        a_next = a_reg;
        ka_next = ka_reg;
        ideal_next = ideal_reg;
        sum_next = sum_reg;
        smin_next = smin_reg;
        smax_next = smax_reg;
        serr_next = serr_reg;
        res_next = res_reg;
        last_next = last_reg;
        mv_next = mv_reg && !m_tready;
        div_start = 1'b0;
        div_neg = 1'b0;
        div_dvd = 24'h010000;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    qang_next = in_ang;
                    res_next = '0;
                    last_next = 1'b1;
                    case (in_cmd)
                        CMD_FINALIZE: state_next = S_FCHK;
                        CMD_QUERY: begin
                            if (!cal_reg || ecnt_reg == 7'd0 || ecnt_reg > 7'(MaxEdges)) begin
                                res_next.status = ST_NOT_CAL;
                                state_next = S_EMIT;
                            end else if (hv_reg && {1'b0, hint_reg} < ecnt_reg) begin
                                i_next = hint_reg;
                                ph_next = 2'd0;
                                state_next = S_QRDA;
                            end else begin
                                i_next = '0;
                                ph_next = 2'd3;
                                state_next = S_QRDA;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FCHK: begin
                if (slot_reg == 7'd0 || tooth_reg == 7'd0 || ecnt_reg == 7'd0 ||
                    ecnt_reg > 7'(MaxEdges) ||
                    {1'b0, ecnt_reg} != ({1'b0, slot_reg} + {1'b0, tooth_reg})) begin
                    res_next.status = ST_RANGE;
                    state_next = S_EMIT;
                end else begin
                    i_next = '0;
                    state_next = S_FKRD;
                end
            end
            S_FKRD: state_next = S_FKCHK;
            S_FKCHK: begin
                if (rd_kind[1]) begin
                    cal_next = 1'b0;
                    res_next.status = ST_RANGE;
                    state_next = S_EMIT;
                end else if (i_reg == nmax) begin
                    div_start = 1'b1;
                    i_next = '0;
                    sum_next = '0;
                    smin_next = 18'sh10000;
                    smax_next = '0;
                    serr_next = '0;
                    state_next = S_FDIV;
                end else begin
                    i_next = 6'(i_reg + 6'd1);
                    state_next = S_FKRD;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    ideal_next = div_q;
                    state_next = S_FRDA;
                end
            end
            S_FRDA: state_next = S_FRDB;
            S_FRDB: begin
                a_next = rd_ang;
                ka_next = rd_kind;
                state_next = S_FCALC;
            end
            S_FCALC: begin
                if (!mv_reg || m_tready) begin
                    res_next = '0;
                    res_next.status = ST_OK;
                    res_next.kind = ka_reg[0];
                    res_next.region_index = i_reg;
                    res_next.midpoint = 16'((({1'b0, a_reg, 1'b0} + 18'(sp)) >> 1));
                    res_next.spacing = sp;
                    sum_next = sum_reg + 24'(sp);
                    if (sp < smin_reg) smin_next = sp;
                    if (sp > signed'({1'b0, smax_reg})) smax_next = 17'(sp);
                    if ((err < 0 ? 19'(-err) : err) > 19'(serr_reg))
                        serr_next = 18'(err < 0 ? -err : err);
                    if (i_reg == nmax) begin
                        div_start = 1'b1;
                        div_neg = (sum_reg + 24'(sp)) < 0;
                        div_dvd = div_neg ? 24'(-(sum_reg + 24'(sp)))
                                          : 24'(sum_reg + 24'(sp));
                        state_next = S_FMEAN;
                    end else begin
                        last_next = 1'b0;
                        mv_next = 1'b1;
                        i_next = 6'(i_reg + 6'd1);
                        state_next = S_FRDA;
                    end
                end
            end
            S_FMEAN: begin
                if (div_done) begin
                    res_next.spacing_lo = smin_reg;
                    res_next.spacing_hi = smax_reg;
                    res_next.spacing_mean = div_q[17:0];
                    res_next.spacing_dev = serr_reg;
                    last_next = 1'b1;
                    hv_next = 1'b0;
                    cal_next = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_QRDA: state_next = S_QRDB;
            S_QRDB: begin
                a_next = rd_ang;
                ka_next = rd_kind;
                state_next = S_QCHK;
            end
            S_QCHK: begin
                if (rel < span) begin
                    hint_next = i_reg;
                    if (ph_reg == 2'd3) hv_next = 1'b1;
                    res_next.region_index = i_reg;
                    if (ka_reg[1]) begin
                        res_next.status = ST_RANGE;
                    end else begin
                        res_next.status = ST_OK;
                        res_next.kind = ka_reg[0];
                    end
                    state_next = S_EMIT;
                end else begin
                    state_next = S_QRDA;
                    case (ph_reg)
                        2'd0: begin
                            i_next = nx;
                            ph_next = 2'd1;
                        end
                        2'd1: begin
                            i_next = (hint_reg == 6'd0) ? nmax : 6'(hint_reg - 6'd1);
                            ph_next = 2'd2;
                        end
                        2'd2: begin
                            i_next = '0;
                            ph_next = 2'd3;
                        end
                        default: begin
                            if (i_reg == nmax) begin
                                hv_next = 1'b0;
                                res_next.status = ST_NOT_FOUND;
                                state_next = S_EMIT;
                            end else begin
                                i_next = 6'(i_reg + 6'd1);
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cal_reg <= 1'b0;
            hint_reg <= '0;
            hv_reg <= 1'b0;
            mv_reg <= 1'b0;
            slot_reg <= '0;
            tooth_reg <= '0;
            ecnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cal_reg <= cal_next;
            hint_reg <= hint_next;
            hv_reg <= hv_next;
            mv_reg <= mv_next;
            if (wr_cfg) begin
                case (paddr[3:2])
                    RegSlot:  slot_reg <= pwdata[6:0];
                    RegTooth: tooth_reg <= pwdata[6:0];
                    RegEdge:  ecnt_reg <= pwdata[6:0];
                    default:  ;
                endcase
            end
        end
        qang_reg <= qang_next;
        i_reg <= i_next;
        ph_reg <= ph_next;
        a_reg <= a_next;
        ka_reg <= ka_next;
        ideal_reg <= ideal_next;
        sum_reg <= sum_next;
        smin_reg <= smin_next;
        smax_reg <= smax_next;
        serr_reg <= serr_next;
        // output register holds while its item waits, else it tracks the result being built
        if (!mv_reg || m_tready) begin
            res_reg <= res_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {{(120 - $bits(result_t)){1'b0}}, res_reg};
    assign m_tlast = last_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cal_reg) |-> $past(state_reg) == S_FMEAN) else $error("bad calibrate");
`endif
endmodule
